// ===== rtl/npm_pkg.sv =====
// ----------------------------------------------------------------------------
// npm_pkg
// Shared types and constants for the polynomial multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package npm_pkg;

  localparam int unsigned CoefW = 30;
  localparam int unsigned LenW  = 6;
  localparam int unsigned DegW  = 6;
  localparam int unsigned NeedW = 7;
  localparam int unsigned MulCntW = 5;

  localparam logic [CoefW-1:0] Modulus = 30'd998244353;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_KINIT,
    ST_IADDR,
    ST_JCHK,
    ST_RD,
    ST_MUL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mul_ctrl_t;

  // a + b mod p, both operands below p
  function automatic logic [CoefW-1:0] add_mod(input logic [CoefW-1:0] a,
                                               input logic [CoefW-1:0] b);
    logic [CoefW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, Modulus}) s = s - {1'b0, Modulus};
    return s[CoefW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/npm_coef_ram.sv =====
// ----------------------------------------------------------------------------
// npm_coef_ram
// Coefficient store, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module npm_coef_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AddrW-1:0]         waddr_i,
  input  wire logic [npm_pkg::CoefW-1:0] wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AddrW-1:0]         raddr_i,
  output logic      [npm_pkg::CoefW-1:0] rdata_o
);

  logic [npm_pkg::CoefW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/npm_mulmod.sv =====
// ----------------------------------------------------------------------------
// npm_mulmod
// Bit-serial modular multiplier, one bit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module npm_mulmod (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [npm_pkg::CoefW-1:0] a_i,
  input  wire logic [npm_pkg::CoefW-1:0] b_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic      [npm_pkg::CoefW-1:0] prod_o
);

  logic [npm_pkg::CoefW-1:0]   a_q, b_q, r_q, r_d, dbl;
  logic [npm_pkg::MulCntW-1:0] cnt_q;
  logic                        busy_q, done_q;

  always_comb begin
    dbl = npm_pkg::add_mod(r_q, r_q);
    r_d = b_q[npm_pkg::CoefW-1] ? npm_pkg::add_mod(dbl, a_q) : dbl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == npm_pkg::MulCntW'(npm_pkg::CoefW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= r_d;
      b_q <= {b_q[npm_pkg::CoefW-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = r_q;

endmodule

`default_nettype wire

// ===== rtl/ntt_polynomial_multiplier.sv =====
// ----------------------------------------------------------------------------
// ntt_polynomial_multiplier
// Product of two polynomials modulo 998244353, one shared serial multiplier.
// ----------------------------------------------------------------------------
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+-------------------------------
// in      | request   | in_valid_i/in_ready_o | command, coefficient, last
// out     | result    | out_valid_o/out_ready_i | product_coefficient, degree,
//         |           |                      | final_item, overflow
//
// Loads are taken back to back while idle. A B request marked last starts the
// product: each output degree k sums A[i]*B[j] over (i+j) mod n == k mod n,
// n the power of two >= lenA+lenB-1 capped at TRANSFORM_SIZE (cyclic wrap).
// Each term passes through a read, the bit-serial multiplier and a next j
// check, so without stalls the multiplier sets the pace of a product.
// Input is not ready during the product; a stalled result just holds.
// Reset clears lengths, overflow flag and the sequencer; stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ntt_polynomial_multiplier #(
  parameter int unsigned MAX_LEN        = 32,
  parameter int unsigned TRANSFORM_SIZE = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      command_i,
  input  wire logic [npm_pkg::CoefW-1:0] coefficient_i,
  input  wire logic                      last_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [npm_pkg::CoefW-1:0] product_coefficient_o,
  output logic      [npm_pkg::DegW-1:0]  degree_index_o,
  output logic                           final_item_o,
  output logic                           overflow_o
);

  localparam int unsigned AddrW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [npm_pkg::LenW-1:0]  MaxLen = npm_pkg::LenW'(MAX_LEN);
  localparam logic [npm_pkg::NeedW:0]   TSize  = (npm_pkg::NeedW + 1)'(TRANSFORM_SIZE);

  npm_pkg::state_e state_q, state_d;

  logic [npm_pkg::LenW-1:0]  len_a_q, len_b_q;
  logic                      ovf_q;
  logic [npm_pkg::NeedW-1:0] need_q;
  logic [npm_pkg::NeedW:0]   n_q, n_calc;
  logic [npm_pkg::DegW-1:0]  k_q, i_q;
  logic [npm_pkg::NeedW-1:0] j_q;
  logic [npm_pkg::CoefW-1:0] acc_q;
  logic [npm_pkg::CoefW-1:0] coef_red, rd_a, rd_b, prod;
  logic [npm_pkg::DegW-1:0]  mask, j_base;
  logic                      in_fire, out_fire, we_a, we_b, rd_en, last_out;
  npm_pkg::mul_ctrl_t        mul;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;
  assign coef_red = (coefficient_i >= npm_pkg::Modulus) ?
                    coefficient_i - npm_pkg::Modulus : coefficient_i;
  assign we_a = in_fire & ~command_i & (len_a_q < MaxLen);
  assign we_b = in_fire &  command_i & (len_b_q < MaxLen);

  // transform size: smallest power of two covering the product, capped
  always_comb begin
    n_calc = (npm_pkg::NeedW + 1)'(1);
    for (int s = 0; s < npm_pkg::NeedW; s++) begin
      if ((n_calc < {1'b0, need_q}) && (n_calc < TSize)) n_calc = n_calc << 1;
    end
  end

  assign mask     = npm_pkg::DegW'(n_q - 1'b1);
  assign j_base   = (k_q - i_q) & mask;
  assign rd_en    = (state_q == npm_pkg::ST_JCHK) && (j_q < {1'b0, len_b_q});
  assign last_out = ({1'b0, k_q} == need_q - 1'b1);

  npm_coef_ram #(.Depth(MAX_LEN), .AddrW(AddrW)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (len_a_q[AddrW-1:0]),
    .wdata_i (coef_red),
    .re_i    (rd_en),
    .raddr_i (i_q[AddrW-1:0]),
    .rdata_o (rd_a)
  );

  npm_coef_ram #(.Depth(MAX_LEN), .AddrW(AddrW)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (len_b_q[AddrW-1:0]),
    .wdata_i (coef_red),
    .re_i    (rd_en),
    .raddr_i (j_q[AddrW-1:0]),
    .rdata_o (rd_b)
  );

  assign mul.start = (state_q == npm_pkg::ST_RD);

  npm_mulmod u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul.start),
    .a_i     (rd_a),
    .b_i     (rd_b),
    .busy_o  (mul.busy),
    .done_o  (mul.done),
    .prod_o  (prod)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      npm_pkg::ST_IDLE: begin
        if (in_fire && command_i && last_i) begin
          // the B length seen here excludes this request; test the updated one
          if (len_a_q == '0 || (len_b_q == '0 && !we_b)) state_d = npm_pkg::ST_IDLE;
          else state_d = npm_pkg::ST_SETUP;
        end
      end
      npm_pkg::ST_SETUP: state_d = npm_pkg::ST_KINIT;
      npm_pkg::ST_KINIT: state_d = npm_pkg::ST_IADDR;
      npm_pkg::ST_IADDR: begin
        state_d = ({1'b0, i_q} >= {1'b0, len_a_q}) ? npm_pkg::ST_EMIT : npm_pkg::ST_JCHK;
      end
      npm_pkg::ST_JCHK: state_d = rd_en ? npm_pkg::ST_RD : npm_pkg::ST_IADDR;
      npm_pkg::ST_RD:   state_d = npm_pkg::ST_MUL;
      npm_pkg::ST_MUL:  if (mul.done) state_d = npm_pkg::ST_JCHK;
      npm_pkg::ST_EMIT: begin
        if (out_ready_i) state_d = last_out ? npm_pkg::ST_IDLE : npm_pkg::ST_KINIT;
      end
      default: state_d = npm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= npm_pkg::ST_IDLE;
      len_a_q <= '0;
      len_b_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        if (we_a) len_a_q <= len_a_q + 1'b1;
        if (we_b) len_b_q <= len_b_q + 1'b1;
        if (!we_a && !we_b) ovf_q <= 1'b1;
        if (command_i && last_i && state_d == npm_pkg::ST_IDLE) begin
          len_a_q <= '0;
          len_b_q <= '0;
          ovf_q   <= 1'b0;
        end
      end
      if (out_fire && last_out) begin
        len_a_q <= '0;
        len_b_q <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      npm_pkg::ST_IDLE: begin
        need_q <= npm_pkg::NeedW'({1'b0, len_a_q} + {1'b0, len_b_q} + (we_b ? 1'b1 : 1'b0))
                  - 1'b1;
        k_q    <= '0;
      end
      npm_pkg::ST_SETUP: n_q <= n_calc;
      npm_pkg::ST_KINIT: begin
        acc_q <= '0;
        i_q   <= '0;
      end
      npm_pkg::ST_IADDR: j_q <= {1'b0, j_base};
      npm_pkg::ST_JCHK: if (!rd_en) i_q <= i_q + 1'b1;
      npm_pkg::ST_MUL: begin
        if (mul.done) begin
          acc_q <= npm_pkg::add_mod(acc_q, prod);
          j_q   <= j_q + n_q[npm_pkg::NeedW-1:0];
        end
      end
      npm_pkg::ST_EMIT: if (out_ready_i && !last_out) k_q <= k_q + 1'b1;
      default: ;
    endcase
  end

  assign in_ready_o            = (state_q == npm_pkg::ST_IDLE);
  assign out_valid_o           = (state_q == npm_pkg::ST_EMIT);
  assign product_coefficient_o = acc_q;
  assign degree_index_o        = k_q;
  assign final_item_o          = last_out;
  assign overflow_o            = ovf_q;

  // checks
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && in_ready_o)) else $error("in and out active together");
  a_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, degree_index_o} < need_q)) else $error("degree beyond product");
  a_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul.busy |-> (state_q == npm_pkg::ST_MUL)) else $error("multiplier busy out of step");
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_a_q <= MaxLen) && (len_b_q <= MaxLen)) else $error("length beyond store");

endmodule

`default_nettype wire
